// ===== rtl/core/tgtg_pkg.sv =====
// ----------------------------------------------------------------------------
// tgtg_pkg
// Shared types, codes and helpers of the task graph traffic generator node.
// ----------------------------------------------------------------------------
package tgtg_pkg;

  localparam int DATA_W            = 16;
  localparam int CNT_W             = 8;
  localparam int MESH_NODES        = 64;
  localparam int NODE_W            = $clog2(MESH_NODES);
  localparam int CFG_IDX_W         = 3;
  localparam int DEF_TABLE_ENTRIES = 8;
  localparam int SLOT_W            = 3;
  localparam int CMD_W             = 3;
  localparam int PHASE_W           = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_RECV     = 3'd1,
    CMD_LOAD_SRC = 3'd2,
    CMD_LOAD_DST = 3'd3,
    CMD_START    = 3'd4
  } cmd_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_RELEASED = 3'd0,
    PH_WAIT     = 3'd1,
    PH_RECEIVE  = 3'd2,
    PH_COMPUTE  = 3'd3,
    PH_SEND     = 3'd4,
    PH_FINISH   = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECV_THRESHOLD = 3'd0,
    REG_SEND_TOTAL     = 3'd1,
    REG_COMPUTE_CYCLES = 3'd2,
    REG_SEND_INTERVAL  = 3'd3,
    REG_PERIOD         = 3'd4,
    REG_EXEC_COUNT     = 3'd5,
    REG_NODE_ID        = 3'd6,
    REG_PACKET_LEN     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic take;   // latch the input beat, start scan and divider
    logic scan;   // table scan step
    logic exec;   // commit the item and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic work_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [DATA_W-1:0] inc_sat(input logic [DATA_W-1:0] v);
    return (v != '1) ? v + DATA_W'(1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] dec_sat(input logic [DATA_W-1:0] v);
    return (v != '0) ? v - DATA_W'(1) : v;
  endfunction

endpackage

// ===== rtl/core/tgtg_mod.sv =====
// ----------------------------------------------------------------------------
// tgtg_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tgtg_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tgtg_pkg::DATA_W-1:0] dividend,
  input  logic [tgtg_pkg::DATA_W-1:0] divisor,
  output logic [tgtg_pkg::DATA_W-1:0] rem,
  output logic                        done
);
  import tgtg_pkg::*;

  localparam int STEP_W = $clog2(DATA_W + 1);

  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] shreg;
  logic [DATA_W:0]   trial;

  assign done  = (step == STEP_W'(DATA_W));
  assign trial = {rem, shreg[DATA_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_W'(DATA_W);
    end else if (start) begin
      step <= '0;
    end else if (!done) begin
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (!done) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= DATA_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DATA_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/tgtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgtg_ctrl
// Item sequencer: accept, scan/divide, commit into the result register.
// ----------------------------------------------------------------------------
module tgtg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output tgtg_pkg::ctrl_cmd_t    ctl,
  input  tgtg_pkg::dp_status_t   st
);
  import tgtg_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_WORK;
      S_WORK: if (st.work_done) state_next = S_EXEC;
      S_EXEC: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      S_WORK: ctl.scan = 1'b1;
      // result register full and not draining: hold the commit
      S_EXEC: ctl.exec = st.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tgtg_dp.sv =====
// ----------------------------------------------------------------------------
// tgtg_dp
// Datapath: config registers, source/destination tables, phase counters,
// table scan and the result register.
// ----------------------------------------------------------------------------
module tgtg_dp #(
  parameter int TABLE_ENTRIES = tgtg_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tgtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgtg_pkg::DATA_W-1:0]    cfg_data,
  input  logic [tgtg_pkg::CMD_W-1:0]     cmd,
  input  logic [tgtg_pkg::NODE_W-1:0]    src_addr,
  input  logic [tgtg_pkg::SLOT_W-1:0]    entry_index,
  input  logic [tgtg_pkg::NODE_W-1:0]    entry_addr,
  input  logic [tgtg_pkg::CNT_W-1:0]     entry_count,
  input  tgtg_pkg::ctrl_cmd_t            ctl,
  output tgtg_pkg::dp_status_t           st,
  output logic [tgtg_pkg::DATA_W-1:0]    mod_dividend,
  output logic [tgtg_pkg::DATA_W-1:0]    mod_divisor,
  input  logic [tgtg_pkg::DATA_W-1:0]    mod_rem,
  input  logic                           mod_done,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [tgtg_pkg::PHASE_W-1:0]   phase,
  output logic                           send_valid,
  output logic [tgtg_pkg::NODE_W-1:0]    send_dst,
  output logic                           stray_packet
);
  import tgtg_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // configuration
  logic [DATA_W-1:0] recv_threshold, send_total, compute_cycles;
  logic [DATA_W-1:0] send_interval, period, exec_count;

  // tables
  logic [NODE_W-1:0] src_tab_addr [TABLE_ENTRIES];
  logic [CNT_W-1:0]  src_tab_count[TABLE_ENTRIES];
  logic [NODE_W-1:0] dst_tab_addr [TABLE_ENTRIES];
  logic [CNT_W-1:0]  dst_tab_quota[TABLE_ENTRIES];
  logic [CNT_W-1:0]  dst_remaining[TABLE_ENTRIES];

  // task state
  phase_t            phase_reg, phase_next;
  logic [DATA_W-1:0] recv_counter, recv_counter_next;
  logic [DATA_W-1:0] batches_ready, batches_ready_next;
  logic [DATA_W-1:0] compute_counter, compute_counter_next;
  logic [DATA_W-1:0] sent_counter, sent_counter_next;
  logic [DATA_W-1:0] pace_counter, pace_counter_next;
  logic [DATA_W-1:0] pending_releases, pending_releases_next;
  logic [DATA_W-1:0] runs_remaining, runs_remaining_next;
  logic [DATA_W-1:0] period_phase, period_phase_next;

  // latched input beat
  cmd_t              hold_cmd;
  logic [NODE_W-1:0] hold_src;
  logic [SLOT_W-1:0] hold_idx;
  logic [NODE_W-1:0] hold_addr;
  logic [CNT_W-1:0]  hold_count;

  // scan
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_done;
  logic              scan_good;
  logic              dst_found;
  logic [IDX_W-1:0]  dst_idx;

  // commit controls
  logic              ld_ok;
  logic [IDX_W-1:0]  ld_idx;
  logic              ld_src, ld_dst, refill, rem_dec;
  logic              res_send, res_stray;
  logic [NODE_W-1:0] res_dst;

  // result register
  phase_t            out_phase;

  assign ld_ok  = (int'(hold_idx) < TABLE_ENTRIES);
  assign ld_idx = IDX_W'(hold_idx);

  assign mod_dividend = period_phase + DATA_W'(1);
  assign mod_divisor  = period;

  always_comb begin
    st.out_free = !out_valid || out_ready;
    unique case (hold_cmd)
      CMD_TICK: st.work_done = scan_done && mod_done;
      CMD_RECV: st.work_done = scan_done;
      default:  st.work_done = 1'b1;
    endcase
  end

  assign phase        = PHASE_W'(out_phase);

  // configuration writes; node_id and packet_len reach no result field,
  // so nothing is held for them here
  always_ff @(posedge clk) begin
    if (rst) begin
      recv_threshold <= '0;
      send_total     <= '0;
      compute_cycles <= '0;
      send_interval  <= DATA_W'(1);
      period         <= '0;
      exec_count     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index)) inside
        REG_RECV_THRESHOLD: recv_threshold <= cfg_data;
        REG_SEND_TOTAL:     send_total     <= cfg_data;
        REG_COMPUTE_CYCLES: compute_cycles <= cfg_data;
        REG_SEND_INTERVAL:  send_interval  <= cfg_data;
        REG_PERIOD:         period         <= cfg_data;
        REG_EXEC_COUNT:     exec_count     <= cfg_data;
        REG_NODE_ID, REG_PACKET_LEN: ;
        default: ;
      endcase
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      hold_cmd   <= cmd_t'(cmd);
      hold_src   <= src_addr;
      hold_idx   <= entry_index;
      hold_addr  <= entry_addr;
      hold_count <= entry_count;
    end
  end

  // table scan, one slot per cycle: source match and first live dest slot
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b1;
      scan_idx  <= '0;
      scan_good <= 1'b0;
      dst_found <= 1'b0;
    end else if (ctl.take) begin
      scan_done <= 1'b0;
      scan_idx  <= '0;
      scan_good <= 1'b0;
      dst_found <= 1'b0;
    end else if (ctl.scan && !scan_done) begin
      if (src_tab_addr[scan_idx] == hold_src && src_tab_count[scan_idx] != '0) begin
        scan_good <= 1'b1;
      end
      if (!dst_found && dst_remaining[scan_idx] != '0) begin
        dst_found <= 1'b1;
      end
      if (scan_idx == LAST_IDX) begin
        scan_done <= 1'b1;
      end else begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan && !scan_done && !dst_found && dst_remaining[scan_idx] != '0) begin
      dst_idx <= scan_idx;
    end
  end

  // item commit
  always_comb begin
    phase_next            = phase_reg;
    recv_counter_next     = recv_counter;
    batches_ready_next    = batches_ready;
    compute_counter_next  = compute_counter;
    sent_counter_next     = sent_counter;
    pace_counter_next     = pace_counter;
    pending_releases_next = pending_releases;
    runs_remaining_next   = runs_remaining;
    period_phase_next     = period_phase;
    ld_src    = 1'b0;
    ld_dst    = 1'b0;
    refill    = 1'b0;
    rem_dec   = 1'b0;
    res_send  = 1'b0;
    res_stray = 1'b0;
    res_dst   = '0;
    unique case (hold_cmd)
      CMD_TICK: begin
        // source task release counter; mod_rem is (period_phase + 1) % period
        if (phase_reg != PH_RELEASED && recv_threshold == '0) begin
          period_phase_next = period_phase + DATA_W'(1);
          if (period != '0) begin
            if (mod_rem == DATA_W'(1) && pending_releases < runs_remaining) begin
              pending_releases_next = pending_releases + DATA_W'(1);
            end
          end else begin
            pending_releases_next = DATA_W'(1);
          end
        end
        case (phase_reg)
          PH_WAIT: begin
            if (recv_threshold == '0 && pending_releases_next != '0) begin
              phase_next            = PH_COMPUTE;
              runs_remaining_next   = dec_sat(runs_remaining);
              pending_releases_next = pending_releases_next - DATA_W'(1);
            end
          end
          PH_RECEIVE: begin
            if (batches_ready != '0) begin
              phase_next          = PH_COMPUTE;
              runs_remaining_next = dec_sat(runs_remaining);
              batches_ready_next  = batches_ready - DATA_W'(1);
            end
          end
          PH_COMPUTE: begin
            compute_counter_next = inc_sat(compute_counter);
            if (compute_counter_next >= compute_cycles) begin
              if (send_total == '0) begin
                phase_next           = PH_FINISH;
                compute_counter_next = '0;
              end else begin
                phase_next = PH_SEND;
              end
            end
          end
          PH_SEND: begin
            if (pace_counter == '0) begin
              if (dst_found) begin
                res_send          = 1'b1;
                res_dst           = dst_tab_addr[dst_idx];
                rem_dec           = 1'b1;
                sent_counter_next = inc_sat(sent_counter);
              end
              // an interval of zero paces like one
              pace_counter_next = (send_interval != '0) ? send_interval - DATA_W'(1) : '0;
            end else begin
              pace_counter_next = pace_counter - DATA_W'(1);
            end
            if (sent_counter_next >= send_total) begin
              phase_next        = PH_FINISH;
              sent_counter_next = '0;
            end
          end
          PH_FINISH: begin
            if (runs_remaining != '0) begin
              phase_next           = (batches_ready != '0) ? PH_RECEIVE : PH_WAIT;
              sent_counter_next    = '0;
              compute_counter_next = '0;
              refill               = 1'b1;
            end else begin
              phase_next = PH_RELEASED;
            end
          end
          default: ;
        endcase
      end
      CMD_RECV: begin
        if (!scan_good) begin
          res_stray = 1'b1;
        end else begin
          if (phase_reg == PH_WAIT) phase_next = PH_RECEIVE;
          recv_counter_next = inc_sat(recv_counter);
          if (recv_counter_next >= recv_threshold) begin
            batches_ready_next = inc_sat(batches_ready);
            recv_counter_next  = '0;
          end
        end
      end
      CMD_LOAD_SRC: ld_src = ld_ok;
      CMD_LOAD_DST: ld_dst = ld_ok;
      CMD_START: begin
        phase_next            = PH_WAIT;
        recv_counter_next     = '0;
        batches_ready_next    = '0;
        compute_counter_next  = '0;
        sent_counter_next     = '0;
        pace_counter_next     = '0;
        pending_releases_next = '0;
        period_phase_next     = '0;
        runs_remaining_next   = exec_count;
        refill                = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= PH_RELEASED;
      recv_counter     <= '0;
      batches_ready    <= '0;
      compute_counter  <= '0;
      sent_counter     <= '0;
      pace_counter     <= '0;
      pending_releases <= '0;
      runs_remaining   <= '0;
      period_phase     <= '0;
      src_tab_addr     <= '{default: '0};
      src_tab_count    <= '{default: '0};
      dst_tab_addr     <= '{default: '0};
      dst_tab_quota    <= '{default: '0};
      dst_remaining    <= '{default: '0};
    end else if (ctl.exec) begin
      phase_reg        <= phase_next;
      recv_counter     <= recv_counter_next;
      batches_ready    <= batches_ready_next;
      compute_counter  <= compute_counter_next;
      sent_counter     <= sent_counter_next;
      pace_counter     <= pace_counter_next;
      pending_releases <= pending_releases_next;
      runs_remaining   <= runs_remaining_next;
      period_phase     <= period_phase_next;
      if (refill) dst_remaining <= dst_tab_quota;
      if (rem_dec) dst_remaining[dst_idx] <= dst_remaining[dst_idx] - CNT_W'(1);
      if (ld_src) begin
        src_tab_addr[ld_idx]  <= hold_addr;
        src_tab_count[ld_idx] <= hold_count;
      end
      if (ld_dst) begin
        dst_tab_addr[ld_idx]  <= hold_addr;
        dst_tab_quota[ld_idx] <= hold_count;
        dst_remaining[ld_idx] <= hold_count;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_phase    <= phase_next;
      send_valid   <= res_send;
      send_dst     <= res_dst;
      stray_packet <= res_stray;
    end
  end

endmodule

// ===== rtl/core/task_graph_traffic_generator_top.sv =====
// ----------------------------------------------------------------------------
// task_graph_traffic_generator_top
// Network-on-chip task node: table loads, receive checks, phase sequencing
// and paced packet sends, one result beat per command beat.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   cmd, src_addr, entry_index, entry_addr,
//                                 entry_count
//  out      out_valid / out_ready phase, send_valid, send_dst, stray_packet
//  cfg      cfg_we                cfg_index, cfg_data
//
//  One command beat at a time. Loads, start and unknown commands commit
//  without waiting on the table scan; a receive waits for the scan (one
//  table slot per cycle); a tick also waits for the bit-serial remainder
//  unit of the release period. A result beat waits in the output register
//  while the next command beat is accepted; a stalled output holds the
//  commit of that next beat. Synchronous reset clears tables and counters.
// ----------------------------------------------------------------------------
module task_graph_traffic_generator_top #(
  parameter int TABLE_ENTRIES = tgtg_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tgtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgtg_pkg::DATA_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tgtg_pkg::CMD_W-1:0]     cmd,
  input  logic [tgtg_pkg::NODE_W-1:0]    src_addr,
  input  logic [tgtg_pkg::SLOT_W-1:0]    entry_index,
  input  logic [tgtg_pkg::NODE_W-1:0]    entry_addr,
  input  logic [tgtg_pkg::CNT_W-1:0]     entry_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tgtg_pkg::PHASE_W-1:0]   phase,
  output logic                           send_valid,
  output logic [tgtg_pkg::NODE_W-1:0]    send_dst,
  output logic                           stray_packet
);
  import tgtg_pkg::*;

  ctrl_cmd_t         ctl;
  dp_status_t        st;
  logic [DATA_W-1:0] mod_dividend, mod_divisor, mod_rem;
  logic              mod_done;

  tgtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .st       (st)
  );

  tgtg_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.take),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  tgtg_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .src_addr     (src_addr),
    .entry_index  (entry_index),
    .entry_addr   (entry_addr),
    .entry_count  (entry_count),
    .ctl          (ctl),
    .st           (st),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_rem      (mod_rem),
    .mod_done     (mod_done),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .phase        (phase),
    .send_valid   (send_valid),
    .send_dst     (send_dst),
    .stray_packet (stray_packet)
  );

  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is still in work");

  a_no_accept_on_commit: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && ctl.exec))
    else $error("commit while waiting for an input beat");

  a_commit_fills_out: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> out_valid)
    else $error("commit did not load the result register");

  a_send_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_valid |->
      (phase == PHASE_W'(PH_SEND) || phase == PHASE_W'(PH_FINISH)))
    else $error("packet issued outside the send phase");

  a_send_not_stray: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(send_valid && stray_packet))
    else $error("send and stray flagged in one beat");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the task graph traffic generator node. Table loads,
// receives, ticks, start and unknown commands are offered on the command
// channel; every result beat is checked field by field against an in-bench
// model of the node or a typed row's report. A directed table comes first,
// then random traffic under several configs and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import tgtg_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] src_addr;
    logic [SLOT_W-1:0] entry_index;
    logic [NODE_W-1:0] entry_addr;
    logic [CNT_W-1:0]  entry_count;
  } node_cmd_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               send_valid;
    logic [NODE_W-1:0]  send_dst;
    logic               stray_packet;
  } node_report_t;

  typedef struct {
    node_cmd_t    c;
    bit           typed;
    node_report_t r;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [NODE_W-1:0]    src_addr = '0;
  logic [SLOT_W-1:0]    entry_index = '0;
  logic [NODE_W-1:0]    entry_addr = '0;
  logic [CNT_W-1:0]     entry_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PHASE_W-1:0]   phase;
  logic                 send_valid;
  logic [NODE_W-1:0]    send_dst;
  logic                 stray_packet;

  task_graph_traffic_generator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .src_addr     (src_addr),
    .entry_index  (entry_index),
    .entry_addr   (entry_addr),
    .entry_count  (entry_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .phase        (phase),
    .send_valid   (send_valid),
    .send_dst     (send_dst),
    .stray_packet (stray_packet)
  );

  always #4 clk = ~clk;

  // node model state
  phase_t            m_phase;
  logic [NODE_W-1:0] m_src_addr  [8];
  logic [CNT_W-1:0]  m_src_cnt   [8];
  logic [NODE_W-1:0] m_dst_addr  [8];
  logic [CNT_W-1:0]  m_dst_quota [8];
  logic [CNT_W-1:0]  m_dst_left  [8];
  logic [15:0] m_recv_cnt, m_batches, m_comp_cnt, m_sent_cnt;
  logic [15:0] m_pace, m_releases, m_runs, m_period_ph;
  logic [15:0] c_recv_thr, c_send_total, c_comp_cycles, c_send_int, c_period, c_exec;

  node_report_t phase_reports[$];
  stim_row_t    directed_rows[$];
  int           err_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_req = 0;
  int           hold_left = 0;
  bit           pause_for_drain = 1'b0;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] drop(input logic [15:0] v);
    return (v == 16'd0) ? v : v - 16'd1;
  endfunction

  function automatic void refill_dst_left();
    for (int i = 0; i < 8; i++) m_dst_left[i] = m_dst_quota[i];
  endfunction

  function automatic node_report_t advance_task_node(input node_cmd_t c);
    node_report_t r;
    logic         good;
    logic         found;
    r     = '0;
    good  = 1'b0;
    found = 1'b0;
    case (c.cmd)
      CMD_TICK: begin
        if (m_phase != PH_RELEASED && c_recv_thr == 16'd0) begin
          m_period_ph = m_period_ph + 16'd1;
          if (c_period != 16'd0) begin
            // wrapping phase counter: a period of 1 never hits remainder 1
            if ((m_period_ph % c_period) == 16'd1 && m_releases < m_runs)
              m_releases = m_releases + 16'd1;
          end else begin
            m_releases = 16'd1;
          end
        end
        case (m_phase)
          PH_WAIT: begin
            if (c_recv_thr == 16'd0 && m_releases != 16'd0) begin
              m_phase    = PH_COMPUTE;
              m_runs     = drop(m_runs);
              m_releases = m_releases - 16'd1;
            end
          end
          PH_RECEIVE: begin
            if (m_batches != 16'd0) begin
              m_phase   = PH_COMPUTE;
              m_runs    = drop(m_runs);
              m_batches = m_batches - 16'd1;
            end
          end
          PH_COMPUTE: begin
            m_comp_cnt = bump(m_comp_cnt);
            if (m_comp_cnt >= c_comp_cycles) begin
              if (c_send_total == 16'd0) begin
                m_phase    = PH_FINISH;
                m_comp_cnt = 16'd0;
              end else begin
                m_phase = PH_SEND;
              end
            end
          end
          PH_SEND: begin
            if (m_pace == 16'd0) begin
              for (int i = 0; i < 8; i++) begin
                if (!found && m_dst_left[i] != '0) begin
                  found         = 1'b1;
                  r.send_dst    = m_dst_addr[i];
                  m_dst_left[i] = m_dst_left[i] - 1'b1;
                  m_sent_cnt    = bump(m_sent_cnt);
                end
              end
              r.send_valid = found;
              m_pace = (c_send_int != 16'd0) ? c_send_int - 16'd1 : 16'd0;
            end else begin
              m_pace = m_pace - 16'd1;
            end
            if (m_sent_cnt >= c_send_total) begin
              m_phase    = PH_FINISH;
              m_sent_cnt = 16'd0;
            end
          end
          PH_FINISH: begin
            if (m_runs != 16'd0) begin
              m_phase    = (m_batches != 16'd0) ? PH_RECEIVE : PH_WAIT;
              m_sent_cnt = 16'd0;
              m_comp_cnt = 16'd0;
              refill_dst_left();
            end else begin
              m_phase = PH_RELEASED;
            end
          end
          default: ;
        endcase
      end
      CMD_RECV: begin
        // duplicates: any live slot with the address makes it good
        for (int i = 0; i < 8; i++)
          if (m_src_addr[i] == c.src_addr && m_src_cnt[i] != '0) good = 1'b1;
        if (!good) begin
          r.stray_packet = 1'b1;
        end else begin
          if (m_phase == PH_WAIT) m_phase = PH_RECEIVE;
          m_recv_cnt = bump(m_recv_cnt);
          if (m_recv_cnt >= c_recv_thr) begin
            m_batches  = bump(m_batches);
            m_recv_cnt = 16'd0;
          end
        end
      end
      CMD_LOAD_SRC: begin
        m_src_addr[c.entry_index] = c.entry_addr;
        m_src_cnt[c.entry_index]  = c.entry_count;
      end
      CMD_LOAD_DST: begin
        m_dst_addr[c.entry_index]  = c.entry_addr;
        m_dst_quota[c.entry_index] = c.entry_count;
        m_dst_left[c.entry_index]  = c.entry_count;
      end
      CMD_START: begin
        m_phase     = PH_WAIT;
        m_recv_cnt  = 16'd0;
        m_batches   = 16'd0;
        m_comp_cnt  = 16'd0;
        m_sent_cnt  = 16'd0;
        m_pace      = 16'd0;
        m_releases  = 16'd0;
        m_period_ph = 16'd0;
        m_runs      = c_exec;
        refill_dst_left();
      end
      default: ;
    endcase
    r.phase = m_phase;
    return r;
  endfunction

  task automatic set_reg(input reg_idx_t idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_RECV_THRESHOLD: c_recv_thr    = v;
      REG_SEND_TOTAL:     c_send_total  = v;
      REG_COMPUTE_CYCLES: c_comp_cycles = v;
      REG_SEND_INTERVAL:  c_send_int    = v;
      REG_PERIOD:         c_period      = v;
      REG_EXEC_COUNT:     c_exec        = v;
      default: ;  // node id and packet length do not show in the results
    endcase
  endtask

  task automatic configure(input logic [15:0] thr, input logic [15:0] tot,
                           input logic [15:0] comp, input logic [15:0] intv,
                           input logic [15:0] per, input logic [15:0] runs,
                           input logic [15:0] node, input logic [15:0] plen);
    set_reg(REG_RECV_THRESHOLD, thr);
    set_reg(REG_SEND_TOTAL, tot);
    set_reg(REG_COMPUTE_CYCLES, comp);
    set_reg(REG_SEND_INTERVAL, intv);
    set_reg(REG_PERIOD, per);
    set_reg(REG_EXEC_COUNT, runs);
    set_reg(REG_NODE_ID, node);
    set_reg(REG_PACKET_LEN, plen);
    cfg_we <= 1'b0;
  endtask

  // called at a rising edge; returns at a rising edge
  task automatic offer(input node_cmd_t c, input bit typed, input node_report_t r);
    node_report_t p;
    in_valid    <= 1'b1;
    cmd         <= c.cmd;
    src_addr    <= c.src_addr;
    entry_index <= c.entry_index;
    entry_addr  <= c.entry_addr;
    entry_count <= c.entry_count;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    p = advance_task_node(c);
    phase_reports = {phase_reports, (typed ? r : p)};
    if (pause_for_drain) begin
      pause_for_drain = 1'b0;
      in_valid <= 1'b0;
      while (phase_reports.size() != 0) @(posedge clk);
    end else if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic settle();
    while (phase_reports.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic add_row(input cmd_t op, input int sa, input int idx, input int ea,
                         input int ec, input bit typed, input phase_t ph,
                         input bit st);
    stim_row_t row;
    row.c.cmd         = op;
    row.c.src_addr    = NODE_W'(sa);
    row.c.entry_index = SLOT_W'(idx);
    row.c.entry_addr  = NODE_W'(ea);
    row.c.entry_count = CNT_W'(ec);
    row.typed         = typed;
    row.r             = '0;
    row.r.phase       = ph;
    row.r.stray_packet = st;
    directed_rows = {directed_rows, row};
  endtask

  task automatic random_traffic(input int n, input bit hold_here, input bit pause_here);
    node_cmd_t c;
    int        roll;
    for (int k = 0; k < n; k++) begin
      roll          = $urandom_range(99);
      c.src_addr    = NODE_W'($urandom_range(63));
      c.entry_index = SLOT_W'($urandom_range(7));
      c.entry_addr  = NODE_W'($urandom_range(63));
      c.entry_count = CNT_W'($urandom_range(255));
      if (roll < 55) begin
        c.cmd = CMD_TICK;
      end else if (roll < 85) begin
        c.cmd = CMD_RECV;
        if ($urandom_range(4) != 0) c.src_addr = m_src_addr[$urandom_range(7)];
      end else if (roll < 90) begin
        c.cmd = CMD_LOAD_SRC;
      end else if (roll < 95) begin
        c.cmd = CMD_LOAD_DST;
        if ($urandom_range(1) != 0) c.entry_count = CNT_W'($urandom_range(3));
      end else if (roll < 97) begin
        c.cmd = CMD_START;
      end else begin
        c.cmd = CMD_W'($urandom_range(7, 5));
      end
      if (hold_here && k == n / 3) hold_req = 300;
      if (pause_here && k == (2 * n) / 3) pause_for_drain = 1'b1;
      offer(c, 1'b0, '0);
    end
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    node_report_t e;
    if (!rst && out_valid && out_ready) begin
      if (phase_reports.size() == 0) begin
        $error("unexpected result beat: phase %0d", phase);
        err_cnt++;
      end else begin
        e = phase_reports.pop_front();
        if (phase !== e.phase) begin
          $error("phase: expected %0d, got %0d", e.phase, phase);
          err_cnt++;
        end
        if (send_valid !== e.send_valid) begin
          $error("send_valid: expected %0d, got %0d", e.send_valid, send_valid);
          err_cnt++;
        end
        if (send_dst !== e.send_dst) begin
          $error("send_dst: expected %0d, got %0d", e.send_dst, send_dst);
          err_cnt++;
        end
        if (stray_packet !== e.stray_packet) begin
          $error("stray_packet: expected %0d, got %0d", e.stray_packet, stray_packet);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    node_cmd_t   c;
    logic [15:0] thr, tot, comp, intv, per, runs, node, plen;
    m_phase = PH_RELEASED;
    for (int i = 0; i < 8; i++) begin
      m_src_addr[i]  = '0;
      m_src_cnt[i]   = '0;
      m_dst_addr[i]  = '0;
      m_dst_quota[i] = '0;
      m_dst_left[i]  = '0;
    end
    {m_recv_cnt, m_batches, m_comp_cnt, m_sent_cnt} = '0;
    {m_pace, m_releases, m_runs, m_period_ph} = '0;
    {c_recv_thr, c_send_total, c_comp_cycles, c_period, c_exec} = '0;
    c_send_int = 16'd1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // send interval of zero behaves as one
    configure(16'd2, 16'd3, 16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd63, 16'd255);

    add_row(CMD_TICK,     0,  0,  0,   0, 1, PH_RELEASED, 0);
    add_row(cmd_t'(5),    0,  0,  0,   0, 1, PH_RELEASED, 0);
    add_row(cmd_t'(7),   63,  7, 63, 255, 1, PH_RELEASED, 0);
    add_row(CMD_RECV,    63,  0,  0,   0, 1, PH_RELEASED, 1);
    add_row(CMD_LOAD_SRC, 0,  0, 63, 255, 1, PH_RELEASED, 0);
    add_row(CMD_LOAD_SRC, 0,  7,  0,   1, 1, PH_RELEASED, 0);
    add_row(CMD_LOAD_SRC, 0,  1, 63,   0, 1, PH_RELEASED, 0);  // inert duplicate
    add_row(CMD_LOAD_DST, 0,  0, 63,   1, 1, PH_RELEASED, 0);
    add_row(CMD_LOAD_DST, 0,  7, 21, 255, 1, PH_RELEASED, 0);
    add_row(CMD_LOAD_DST, 0,  3, 42,   0, 1, PH_RELEASED, 0);
    add_row(CMD_START,    0,  0,  0,   0, 1, PH_WAIT,     0);
    add_row(CMD_RECV,    63,  0,  0,   0, 0, PH_WAIT,     0);
    add_row(CMD_RECV,     0,  0,  0,   0, 0, PH_WAIT,     0);
    add_row(CMD_RECV,     5,  0,  0,   0, 0, PH_WAIT,     0);
    repeat (6) add_row(CMD_TICK, 0, 0, 0, 0, 0, PH_WAIT, 0);
    add_row(cmd_t'(6),    0,  0,  0,   0, 0, PH_WAIT,     0);
    add_row(CMD_START,    0,  0,  0,   0, 0, PH_WAIT,     0);
    // quota runs dry before send_total: stuck in send until restarted
    add_row(CMD_RECV,     0,  0,  0,   0, 0, PH_WAIT,     0);
    add_row(CMD_RECV,     0,  0,  0,   0, 0, PH_WAIT,     0);
    add_row(CMD_LOAD_DST, 0,  7, 21,   0, 0, PH_WAIT,     0);
    repeat (5) add_row(CMD_TICK, 0, 0, 0, 0, 0, PH_WAIT, 0);

    foreach (directed_rows[i])
      offer(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      case (p)
        0: {thr, tot, comp, intv, per, runs, node, plen} =
             {16'd0, 16'd2, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd5};
        1: {thr, tot, comp, intv, per, runs, node, plen} =   // period 1: no release
             {16'd0, 16'd2, 16'd1, 16'd1, 16'd1, 16'd5, 16'd12, 16'd64};
        2: {thr, tot, comp, intv, per, runs, node, plen} =
             {16'd0, 16'd2, 16'd2, 16'd2, 16'hFFFF, 16'd3, 16'd33, 16'd200};
        3: {thr, tot, comp, intv, per, runs, node, plen} =
             {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'd255};
        4: {thr, tot, comp, intv, per, runs, node, plen} =
             {16'd0, 16'd40, 16'd0, 16'd1, 16'd0, 16'd4, 16'd0, 16'd1};
        default: begin
          thr  = 16'($urandom_range(4));
          tot  = 16'($urandom_range(6));
          comp = 16'($urandom_range(4));
          intv = 16'($urandom_range(3));
          per  = 16'($urandom_range(5));
          runs = 16'($urandom_range(8));
          node = 16'($urandom_range(63));
          plen = 16'($urandom_range(255, 1));
        end
      endcase
      configure(thr, tot, comp, intv, per, runs, node, plen);

      // well-formed run setup: fill both tables, then start
      for (int i = 0; i < 8; i++) begin
        c.cmd         = CMD_LOAD_SRC;
        c.src_addr    = NODE_W'($urandom_range(63));
        c.entry_index = SLOT_W'(i);
        c.entry_addr  = NODE_W'($urandom_range(63));
        c.entry_count = (i < 6) ? CNT_W'($urandom_range(255, 1)) : CNT_W'($urandom_range(255));
        offer(c, 1'b0, '0);
      end
      for (int i = 0; i < 8; i++) begin
        c.cmd         = CMD_LOAD_DST;
        c.entry_index = SLOT_W'(i);
        c.entry_addr  = NODE_W'($urandom_range(63));
        c.entry_count = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(255))
                                                 : CNT_W'($urandom_range(3));
        offer(c, 1'b0, '0);
      end
      c.cmd = CMD_START;
      offer(c, 1'b0, '0);

      random_traffic(58, (p % 4 == 0) && (p > 0), (p == 6) || (p == 9));
      in_valid <= 1'b0;
      settle();
    end

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
